// ----- rtl/core/gpib_three_wire_handshake_assert.svh -----
// Assertion macros for the three-wire handshake block
`ifndef GPIB_THREE_WIRE_HANDSHAKE_ASSERT_SVH
`define GPIB_THREE_WIRE_HANDSHAKE_ASSERT_SVH
`ifndef ASSERT_OFF
`define GTWH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define GTWH_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define GTWH_ASSERT(label, prop, msg)
`define GTWH_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- rtl/core/gtwh_pkg.sv -----
// Types and constants for the three-wire handshake block
package gtwh_pkg;

   localparam int TIMER_BITS = 16;
   localparam int TIMEOUT_BITS = 16;
   localparam int CMP_BITS = 32;

   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(1200);

   localparam logic [2:0] DRV_NRFD = 3'b001;
   localparam logic [2:0] DRV_NDAC = 3'b010;
   localparam logic [2:0] DRV_DAV  = 3'b100;
   localparam int DAV_BIT  = 2;
   localparam int NDAC_BIT = 1;
   localparam int NRFD_BIT = 0;

   localparam logic CSR_TIMEOUT_TICKS = 1'b0;
   localparam logic CSR_READ_WITH_EOI = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE           = 3'd0,
      PH_L_DAV_ASSERT   = 3'd1,
      PH_L_DAV_RELEASE  = 3'd2,
      PH_T_NDAC_ASSERT  = 3'd3,
      PH_T_NRFD_RELEASE = 3'd4,
      PH_T_NRFD_ASSERT  = 3'd5,
      PH_T_NDAC_RELEASE = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      REQ_TICK   = 2'd0,
      REQ_LISTEN = 2'd1,
      REQ_SEND   = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      STAT_OK          = 3'd0,
      STAT_DAV_ASSERT  = 3'd1,
      STAT_DAV_RELEASE = 3'd2,
      STAT_ATN_DROP    = 3'd3,
      STAT_SEND_FAIL   = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] tx_byte;
      logic       dav_low;
      logic       nrfd_low;
      logic       ndac_low;
      logic       atn_low;
      logic       eoi_low;
      logic [7:0] bus_data;
   } item_type;

   typedef struct packed {
      logic       drive_nrfd;
      logic       drive_ndac;
      logic       drive_dav;
      logic [7:0] data_out;
      logic [7:0] rx_data;
      logic       rx_end;
      logic       busy_res;
      logic       done_res;
      logic [2:0] status;
   } result_type;

endpackage

// ----- rtl/core/gpib_three_wire_handshake.sv -----
// Device-side IEEE-488 three-wire byte handshake engine, one transaction per bus tick
//
// Each req transaction is one tick of the bus: a request code (tick, listen, send),
// the byte to send and the sampled DAV, NRFD, NDAC, ATN, EOI and data lines.
// Each tick yields exactly one rsp transaction: line drive levels, the driven byte,
// the last captured byte with its EOI flag, busy, a one-tick done and a status.
// The csr port writes timeout_ticks (index 0) and read_with_eoi (index 1);
// write only while no handshake is running and no transaction is in flight.
// A request is taken into an input register, then the handshake step logic feeds
// the result register, which holds the result until rsp is taken. One transaction
// is taken every cycle while rsp_ready is high; the phase machine takes one step
// for each transaction.
// When rsp stalls, the result register holds and one further transaction waits in
// the input register; req_ready then drops until the result is taken.
// Reset (synchronous, active high) empties both registers, sets the machine idle
// with NRFD and NDAC driven, clears the timer and captured data, and loads the
// register defaults: timeout_ticks 1200, read_with_eoi 1.
module gpib_three_wire_handshake (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [7:0] req_tx_byte,
   input  logic       req_dav_low,
   input  logic       req_nrfd_low,
   input  logic       req_ndac_low,
   input  logic       req_atn_low,
   input  logic       req_eoi_low,
   input  logic [7:0] req_bus_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_drive_nrfd,
   output logic       rsp_drive_ndac,
   output logic       rsp_drive_dav,
   output logic [7:0] rsp_data_out,
   output logic [7:0] rsp_rx_data,
   output logic       rsp_rx_end,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [2:0] rsp_status,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [15:0] csr_wdata
);

`include "gpib_three_wire_handshake_assert.svh"

   logic                              in_vld_ff, in_vld_in;
   gtwh_pkg::item_type                in_item_ff;
   logic                              out_vld_ff, out_vld_in;
   gtwh_pkg::result_type              out_res_ff, out_res_in;
   logic                              advance;

   logic [gtwh_pkg::TIMEOUT_BITS-1:0] timeout_ff;
   logic                              read_eoi_ff;

   gtwh_pkg::phase_type               phase_ff, phase_in;
   logic [gtwh_pkg::TIMER_BITS-1:0]   wait_timer_ff, wait_timer_in;
   logic                              atn_start_ff, atn_start_in;
   logic [7:0]                        captured_ff, captured_in;
   logic                              cap_end_ff, cap_end_in;
   logic [7:0]                        send_byte_ff, send_byte_in;
   logic [2:0]                        drives_ff, drives_in;

   logic                              done_in;
   gtwh_pkg::status_type              status_in;
   logic                              met;
   logic [gtwh_pkg::TIMER_BITS-1:0]   timer_inc;
   logic                              timed_out;
   logic                              atn_drop;

   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   // wait bookkeeping
   always_comb begin
      timer_inc = (wait_timer_ff == gtwh_pkg::TIMER_MAX) ? wait_timer_ff
                : wait_timer_ff + 1'b1;
      timed_out = (gtwh_pkg::CMP_BITS'(timer_inc) >= gtwh_pkg::CMP_BITS'(timeout_ff))
               || (timer_inc == gtwh_pkg::TIMER_MAX);
      atn_drop  = atn_start_ff && !in_item_ff.atn_low;
      unique case (phase_ff)
         gtwh_pkg::PH_L_DAV_ASSERT:   met = in_item_ff.dav_low;
         gtwh_pkg::PH_L_DAV_RELEASE:  met = !in_item_ff.dav_low;
         gtwh_pkg::PH_T_NDAC_ASSERT:  met = in_item_ff.ndac_low;
         gtwh_pkg::PH_T_NRFD_RELEASE: met = !in_item_ff.nrfd_low;
         gtwh_pkg::PH_T_NRFD_ASSERT:  met = in_item_ff.nrfd_low;
         gtwh_pkg::PH_T_NDAC_RELEASE: met = !in_item_ff.ndac_low;
         default:                     met = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      phase_in      = phase_ff;
      wait_timer_in = wait_timer_ff;
      atn_start_in  = atn_start_ff;
      captured_in   = captured_ff;
      cap_end_in    = cap_end_ff;
      send_byte_in  = send_byte_ff;
      drives_in     = drives_ff;
      done_in       = 1'b0;
      status_in     = gtwh_pkg::STAT_OK;
      unique case (phase_ff)
         gtwh_pkg::PH_IDLE: begin
            priority if (in_item_ff.req_type == gtwh_pkg::REQ_LISTEN) begin
               drives_in     = gtwh_pkg::DRV_NDAC;
               cap_end_in    = 1'b0;
               phase_in      = gtwh_pkg::PH_L_DAV_ASSERT;
               wait_timer_in = '0;
               atn_start_in  = in_item_ff.atn_low;
            end else if (in_item_ff.req_type == gtwh_pkg::REQ_SEND) begin
               send_byte_in  = in_item_ff.tx_byte;
               drives_in     = '0;
               phase_in      = gtwh_pkg::PH_T_NDAC_ASSERT;
               wait_timer_in = '0;
               atn_start_in  = in_item_ff.atn_low;
            end else begin
            end
         end
         gtwh_pkg::PH_L_DAV_ASSERT, gtwh_pkg::PH_L_DAV_RELEASE,
         gtwh_pkg::PH_T_NDAC_ASSERT, gtwh_pkg::PH_T_NRFD_RELEASE,
         gtwh_pkg::PH_T_NRFD_ASSERT, gtwh_pkg::PH_T_NDAC_RELEASE: begin
            if (met) begin
               wait_timer_in = '0;
               atn_start_in  = in_item_ff.atn_low;
               unique case (phase_ff)
                  gtwh_pkg::PH_L_DAV_ASSERT: begin
                     cap_end_in  = read_eoi_ff && in_item_ff.eoi_low;
                     captured_in = in_item_ff.bus_data;
                     drives_in   = gtwh_pkg::DRV_NRFD;
                     phase_in    = gtwh_pkg::PH_L_DAV_RELEASE;
                  end
                  gtwh_pkg::PH_L_DAV_RELEASE: begin
                     drives_in     = gtwh_pkg::DRV_NRFD | gtwh_pkg::DRV_NDAC;
                     phase_in      = gtwh_pkg::PH_IDLE;
                     wait_timer_in = wait_timer_ff;
                     atn_start_in  = atn_start_ff;
                     done_in       = 1'b1;
                  end
                  gtwh_pkg::PH_T_NDAC_ASSERT: begin
                     phase_in = gtwh_pkg::PH_T_NRFD_RELEASE;
                  end
                  gtwh_pkg::PH_T_NRFD_RELEASE: begin
                     drives_in = gtwh_pkg::DRV_DAV;
                     phase_in  = gtwh_pkg::PH_T_NRFD_ASSERT;
                  end
                  gtwh_pkg::PH_T_NRFD_ASSERT: begin
                     phase_in = gtwh_pkg::PH_T_NDAC_RELEASE;
                  end
                  default: begin
                     drives_in     = '0;
                     phase_in      = gtwh_pkg::PH_IDLE;
                     wait_timer_in = wait_timer_ff;
                     atn_start_in  = atn_start_ff;
                     done_in       = 1'b1;
                  end
               endcase
            end else begin
               wait_timer_in = timer_inc;
               if (timed_out || atn_drop) begin
                  done_in  = 1'b1;
                  phase_in = gtwh_pkg::PH_IDLE;
                  priority if (phase_ff == gtwh_pkg::PH_L_DAV_ASSERT) begin
                     drives_in = gtwh_pkg::DRV_NRFD | gtwh_pkg::DRV_NDAC;
                     status_in = timed_out ? gtwh_pkg::STAT_DAV_ASSERT
                               : gtwh_pkg::STAT_ATN_DROP;
                  end else if (phase_ff == gtwh_pkg::PH_L_DAV_RELEASE) begin
                     status_in = timed_out ? gtwh_pkg::STAT_DAV_RELEASE
                               : gtwh_pkg::STAT_ATN_DROP;
                  end else begin
                     drives_in = '0;
                     status_in = timed_out ? gtwh_pkg::STAT_SEND_FAIL
                               : gtwh_pkg::STAT_ATN_DROP;
                  end
               end
            end
         end
         default: begin
            phase_in = gtwh_pkg::PH_IDLE;
         end
      endcase
   end

   // result fields
   always_comb begin
      out_res_in.drive_nrfd = drives_in[gtwh_pkg::NRFD_BIT];
      out_res_in.drive_ndac = drives_in[gtwh_pkg::NDAC_BIT];
      out_res_in.drive_dav  = drives_in[gtwh_pkg::DAV_BIT];
      out_res_in.data_out   = drives_in[gtwh_pkg::DAV_BIT] ? send_byte_in : 8'd0;
      out_res_in.rx_data    = captured_in;
      out_res_in.rx_end     = cap_end_in;
      out_res_in.busy_res   = (phase_in != gtwh_pkg::PH_IDLE);
      out_res_in.done_res   = done_in;
      out_res_in.status     = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff     <= 1'b0;
         out_vld_ff    <= 1'b0;
         timeout_ff    <= gtwh_pkg::TIMEOUT_RESET;
         read_eoi_ff   <= 1'b1;
         phase_ff      <= gtwh_pkg::PH_IDLE;
         wait_timer_ff <= '0;
         atn_start_ff  <= 1'b0;
         captured_ff   <= '0;
         cap_end_ff    <= 1'b0;
         send_byte_ff  <= '0;
         drives_ff     <= gtwh_pkg::DRV_NRFD | gtwh_pkg::DRV_NDAC;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               gtwh_pkg::CSR_TIMEOUT_TICKS: timeout_ff  <= csr_wdata;
               gtwh_pkg::CSR_READ_WITH_EOI: read_eoi_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (advance) begin
            phase_ff      <= phase_in;
            wait_timer_ff <= wait_timer_in;
            atn_start_ff  <= atn_start_in;
            captured_ff   <= captured_in;
            cap_end_ff    <= cap_end_in;
            send_byte_ff  <= send_byte_in;
            drives_ff     <= drives_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.req_type <= req_type;
         in_item_ff.tx_byte  <= req_tx_byte;
         in_item_ff.dav_low  <= req_dav_low;
         in_item_ff.nrfd_low <= req_nrfd_low;
         in_item_ff.ndac_low <= req_ndac_low;
         in_item_ff.atn_low  <= req_atn_low;
         in_item_ff.eoi_low  <= req_eoi_low;
         in_item_ff.bus_data <= req_bus_data;
      end
      if (advance) begin
         out_res_ff <= out_res_in;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_drive_nrfd = out_res_ff.drive_nrfd;
   assign rsp_drive_ndac = out_res_ff.drive_ndac;
   assign rsp_drive_dav  = out_res_ff.drive_dav;
   assign rsp_data_out   = out_res_ff.data_out;
   assign rsp_rx_data    = out_res_ff.rx_data;
   assign rsp_rx_end     = out_res_ff.rx_end;
   assign rsp_busy_res   = out_res_ff.busy_res;
   assign rsp_done_res   = out_res_ff.done_res;
   assign rsp_status     = out_res_ff.status;

   `GTWH_ASSERT(a_fail_needs_done, rsp_valid && (rsp_status != gtwh_pkg::STAT_OK) |-> rsp_done_res, "failure status without done")
   `GTWH_ASSERT(a_done_not_busy, rsp_valid && rsp_done_res |-> !rsp_busy_res, "done while still busy")
   `GTWH_ASSERT(a_data_only_with_dav, rsp_valid && !rsp_drive_dav |-> (rsp_data_out == 8'd0), "data driven without DAV")
   `GTWH_ASSERT(a_timer_bound, (phase_ff != gtwh_pkg::PH_IDLE) |-> ((gtwh_pkg::CMP_BITS'(wait_timer_ff) < gtwh_pkg::CMP_BITS'(timeout_ff)) || (wait_timer_ff == '0)), "wait timer beyond timeout")
   `GTWH_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid && req_ready, "pipeline not empty after reset")

endmodule
